[hdl/field_name_utf8_checker_macros.svh]
// Assertion macros for the field name checker RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef FIELD_NAME_UTF8_CHECKER_MACROS_SVH
`define FIELD_NAME_UTF8_CHECKER_MACROS_SVH

// Whenever cond holds, rhs holds at the next clock edge.
`define FNU8_ASSERT_NEXT(label, clk, rst_n, cond, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (rhs)) \
        else $error("fnu8: next-cycle check failed");

// Whenever cond holds, rhs holds in the same cycle.
`define FNU8_ASSERT_NOW(label, clk, rst_n, cond, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rhs)) \
        else $error("fnu8: same-cycle check failed");

`endif

[hdl/fnu8_pkg.sv]
// Package for the field name UTF-8 checker: transaction types and byte constants.
// Depends on nothing; used by fnu8_name_track and field_name_utf8_checker.
package fnu8_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic       empty_name;
    } t_in_item;

    typedef struct packed {
        logic utf8_ok;
        logic dot_found;
        logic dollar_error;
    } t_out_item;

    localparam int unsigned C_ADDR_W = 3;

    localparam logic [C_ADDR_W-1:0] C_ADDR_DOT_EN    = 3'd0;
    localparam logic [C_ADDR_W-1:0] C_ADDR_DOLLAR_EN = 3'd4;

    localparam logic [7:0] C_ASCII_MAX   = 8'h7F;
    localparam logic [7:0] C_CONT_MASK   = 8'hC0;
    localparam logic [7:0] C_CONT_TAG    = 8'h80;
    localparam logic [7:0] C_LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] C_LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] C_LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] C_LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] C_LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] C_LEAD4_TAG   = 8'hF0;
    localparam logic [7:0] C_SURR_LEAD   = 8'hED;
    localparam logic [7:0] C_SURR_MASK   = 8'hA0;
    localparam logic [7:0] C_CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] C_CHAR_DOT    = 8'h2E;
    localparam logic [7:0] C_CHAR_R      = 8'h72;
    localparam logic [7:0] C_CHAR_E      = 8'h65;
    localparam logic [7:0] C_CHAR_F      = 8'h66;
    localparam logic [7:0] C_CHAR_I      = 8'h69;
    localparam logic [7:0] C_CHAR_D      = 8'h64;
    localparam logic [7:0] C_CHAR_B      = 8'h62;

    localparam logic [2:0] C_COUNT_SAT   = 3'd4;
    localparam logic [2:0] C_COUNT_SHORT = 3'd3;

endpackage

[hdl/fnu8_name_track.sv]
// Per-name state of the field name checker: UTF-8 framing, dot, leading dollar, dbref bytes.
// Depends on fnu8_pkg; instantiated by field_name_utf8_checker.
module fnu8_name_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  fnu8_pkg::t_in_item i_item,
    input  logic               i_dot_en,
    input  logic               i_dollar_en,
    output logic               o_emit,
    output fnu8_pkg::t_out_item o_result
);
    import fnu8_pkg::*;

    logic [1:0] r_cont_left, n_cont_left;
    logic       r_surr_pend, n_surr_pend;
    logic       r_failed,    n_failed;
    logic       r_dot_seen,  n_dot_seen;
    logic       r_dollar,    n_dollar;
    logic [2:0] r_count,     n_count;
    logic [7:0] r_byte1,     n_byte1;
    logic [7:0] r_byte2,     n_byte2;
    logic [7:0] r_byte3,     n_byte3;

    logic [7:0] c;
    logic       ends_name;
    logic       dbref;

    assign c         = i_item.text_byte;
    assign ends_name = i_item.is_last | i_item.empty_name;
    assign o_emit    = i_take & ends_name;

    always_comb begin
        n_cont_left = r_cont_left;
        n_surr_pend = r_surr_pend;
        n_failed    = r_failed;
        n_dot_seen  = r_dot_seen;
        n_dollar    = r_dollar;
        n_count     = r_count;
        n_byte1     = r_byte1;
        n_byte2     = r_byte2;
        n_byte3     = r_byte3;
        if (!i_item.empty_name) begin
            if (r_cont_left != 2'd0) begin
                if ((c & C_CONT_MASK) != C_CONT_TAG) begin
                    n_failed = 1'b1;
                end
                if (r_surr_pend && ((c & C_SURR_MASK) == C_SURR_MASK)) begin
                    n_failed = 1'b1;
                end
                n_surr_pend = 1'b0;
                n_cont_left = r_cont_left - 2'd1;
            end else if (c <= C_ASCII_MAX) begin
                n_cont_left = 2'd0;
            end else if ((c & C_LEAD2_MASK) == C_LEAD2_TAG) begin
                n_cont_left = 2'd1;
            end else if ((c & C_LEAD3_MASK) == C_LEAD3_TAG) begin
                n_cont_left = 2'd2;
                n_surr_pend = (c == C_SURR_LEAD);
            end else if ((c & C_LEAD4_MASK) == C_LEAD4_TAG) begin
                n_cont_left = 2'd3;
            end else begin
                n_failed = 1'b1;
            end
            if (c == C_CHAR_DOT) begin
                n_dot_seen = 1'b1;
            end
            case (r_count)
                3'd0: begin
                    n_dollar = (c == C_CHAR_DOLLAR);
                end
                3'd1: begin
                    n_byte1 = c;
                end
                3'd2: begin
                    n_byte2 = c;
                end
                3'd3: begin
                    n_byte3 = c;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            if (r_count < C_COUNT_SAT) begin
                n_count = r_count + 3'd1;
            end
        end
    end

    always_comb begin
        if (n_count >= C_COUNT_SAT) begin
            dbref = (n_byte1 == C_CHAR_R) && (n_byte2 == C_CHAR_E) && (n_byte3 == C_CHAR_F);
        end else if (n_count == C_COUNT_SHORT) begin
            dbref = ((n_byte1 == C_CHAR_I) && (n_byte2 == C_CHAR_D))
                 || ((n_byte1 == C_CHAR_D) && (n_byte2 == C_CHAR_B));
        end else begin
            dbref = 1'b0;
        end
    end

    assign o_result.utf8_ok      = !n_failed && (n_cont_left == 2'd0);
    assign o_result.dot_found    = i_dot_en && n_dot_seen;
    assign o_result.dollar_error = i_dollar_en && n_dollar && !dbref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont_left <= 2'd0;
            r_surr_pend <= 1'b0;
            r_failed    <= 1'b0;
            r_dot_seen  <= 1'b0;
            r_dollar    <= 1'b0;
            r_count     <= 3'd0;
        end else if (i_take) begin
            if (ends_name) begin
                r_cont_left <= 2'd0;
                r_surr_pend <= 1'b0;
                r_failed    <= 1'b0;
                r_dot_seen  <= 1'b0;
                r_dollar    <= 1'b0;
                r_count     <= 3'd0;
            end else begin
                r_cont_left <= n_cont_left;
                r_surr_pend <= n_surr_pend;
                r_failed    <= n_failed;
                r_dot_seen  <= n_dot_seen;
                r_dollar    <= n_dollar;
                r_count     <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_byte1 <= n_byte1;
            r_byte2 <= n_byte2;
            r_byte3 <= n_byte3;
        end
    end

endmodule

[hdl/field_name_utf8_checker.sv]
// Top level of the field name UTF-8 checker: APB registers, result register, handshakes.
// Depends on fnu8_pkg, fnu8_name_track and field_name_utf8_checker_macros.svh.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  result    out        o_out_valid / i_out_stall   o_out_data (t_out_item)
//  config    in         psel penable pwrite pready  paddr pwdata prdata
//
// One byte is taken per clock while the input is not stalled; a result appears in the cycle after its last byte.
// The result register is the one register stage between the last byte and the result.
// Input stalls only while a result is held and the result side stalls.
// Synchronous reset sets dot checking on and dollar checking off.
`include "field_name_utf8_checker_macros.svh"
module field_name_utf8_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fnu8_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fnu8_pkg::t_out_item               o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fnu8_pkg::C_ADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import fnu8_pkg::*;

    logic      r_dot_en;
    logic      r_dollar_en;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data;
    logic      in_take;
    logic      out_take;
    logic      cfg_write;
    logic      emit;
    t_out_item result;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    always_comb begin
        case (paddr)
            C_ADDR_DOT_EN: begin
                prdata = {31'd0, r_dot_en};
            end
            C_ADDR_DOLLAR_EN: begin
                prdata = {31'd0, r_dollar_en};
            end
            default: begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_en    <= 1'b1;
            r_dollar_en <= 1'b0;
        end else if (cfg_write) begin
            if (paddr == C_ADDR_DOT_EN) begin
                r_dot_en <= pwdata[0];
            end
            if (paddr == C_ADDR_DOLLAR_EN) begin
                r_dollar_en <= pwdata[0];
            end
        end
    end

    fnu8_name_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_item      (i_in_data),
        .i_dot_en    (r_dot_en),
        .i_dollar_en (r_dollar_en),
        .o_emit      (emit),
        .o_result    (result)
    );

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `FNU8_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_take && (i_in_data.is_last || i_in_data.empty_name), o_out_valid)
    `FNU8_ASSERT_NEXT(a_taken_result_clears, i_clk, i_rst_n, out_take && !emit, !o_out_valid)
    `FNU8_ASSERT_NOW(a_stall_needs_result, i_clk, i_rst_n, o_in_stall, o_out_valid)
    `FNU8_ASSERT_NEXT(a_dot_en_written, i_clk, i_rst_n, cfg_write && (paddr == C_ADDR_DOT_EN), r_dot_en == $past(pwdata[0]))

endmodule
